/* hw/rtl/itp_pkg.sv */
// Shared types, character codes and helper functions for the infix-to-postfix converter.
// Depends on nothing; the core and the sequencer refer to it by scoped names.
`default_nettype none

package itp_pkg;

  // Character codes that steer the conversion.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // Precedence levels.
  localparam logic [1:0] PREC_PAREN = 2'd0;
  localparam logic [1:0] PREC_ADD   = 2'd1;
  localparam logic [1:0] PREC_MUL   = 2'd2;
  localparam logic [1:0] PREC_OTHER = 2'd3;

  // One result beat requested by the sequencer.
  typedef struct packed {
    logic       vld;
    logic [7:0] sym;
    logic       last;
    logic       ovf;
  } emit_t;

  // Operator precedence; an opening parenthesis on the stack ranks lowest.
  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    if (c == CH_OPEN) begin
      p = PREC_PAREN;
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      p = PREC_ADD;
    end else if (c == CH_STAR || c == CH_SLASH) begin
      p = PREC_MUL;
    end else begin
      p = PREC_OTHER;
    end
    return p;
  endfunction

  // Letters and digits pass straight through.
  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/itp_in_if.sv */
// Input channel of the converter: one infix character per beat.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface itp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       end_of_expression;

  modport source (output valid, output symbol, output end_of_expression, input ready);
  modport sink   (input valid, input symbol, input end_of_expression, output ready);
endinterface

`default_nettype wire

/* hw/rtl/itp_out_if.sv */
// Result channel of the converter: one postfix character per beat.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface itp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_symbol;
  logic       last;
  logic       overflow;

  modport source (output valid, output out_symbol, output last, output overflow, input ready);
  modport sink   (input valid, input out_symbol, input last, input overflow, output ready);
endinterface

`default_nettype wire

/* hw/rtl/infix_to_postfix_converter_core.sv */
// Infix-to-postfix converter: operator stack in a RAM with registered read.
// A result beat issued by the sequencer is held in the output register; a letter or
// digit passes through the ALNUM state and then the output register.
// One character at a time: a new one is accepted only in the idle state, once the
// previous character and any end-of-expression flush are done.
// Reset (synchronous, active low) empties the stack and clears the drop flag.
`default_nettype none

module infix_to_postfix_converter_core #(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  itp_in_if.sink     in_ch,
  itp_out_if.source  out_ch
);

  localparam int AW = $clog2(STACK_DEPTH);

  itp_pkg::emit_t  emit;
  logic            emit_ok;
  logic            mem_rd_en;
  logic [AW-1:0]   mem_rd_addr;
  logic [7:0]      mem_rd_data;
  logic            mem_wr_en;
  logic [AW-1:0]   mem_wr_addr;
  logic [7:0]      mem_wr_data;

  logic            out_vld_r;
  logic [7:0]      out_sym_r;
  logic            out_last_r;
  logic            out_ovf_r;

  // Operator stack storage.
  itp_ram #(
    .WIDTH (8),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Decode and stack sequencer.
  itp_seq #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_symbol   (in_ch.symbol),
    .in_end      (in_ch.end_of_expression),
    .emit_ok     (emit_ok),
    .emit        (emit),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

  // The output register takes a new beat when it is empty or being drained.
  assign emit_ok = !out_vld_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (emit_ok) begin
      out_vld_r <= emit.vld;
    end
    if (emit_ok && emit.vld) begin
      out_sym_r  <= emit.sym;
      out_last_r <= emit.last;
      out_ovf_r  <= emit.ovf;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.out_symbol = out_sym_r;
  assign out_ch.last       = out_last_r;
  assign out_ch.overflow   = out_ovf_r;

endmodule

`default_nettype wire

/* hw/rtl/itp_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module itp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read; read data holds until the next read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* hw/rtl/itp_seq.sv */
// Sequencer of the converter: decodes a character, pops and pushes the operator stack.
// Depends on itp_pkg; drives the stack RAM ports and requests result beats.
`default_nettype none

module itp_seq #(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [7:0]                     in_symbol,
  input  wire logic                           in_end,
  input  wire logic                           emit_ok,
  output itp_pkg::emit_t                      emit,
  output logic                                mem_rd_en,
  output logic      [$clog2(STACK_DEPTH)-1:0] mem_rd_addr,
  input  wire logic [7:0]                     mem_rd_data,
  output logic                                mem_wr_en,
  output logic      [$clog2(STACK_DEPTH)-1:0] mem_wr_addr,
  output logic      [7:0]                     mem_wr_data
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_ALNUM, ST_POPRD, ST_POPWT, ST_PUSH, ST_ENDCHK, ST_TERM
  } state_t;

  typedef enum logic [1:0] {
    MODE_OP, MODE_CLOSE, MODE_FLUSH
  } mode_t;

  state_t          state_r, state_nxt;
  mode_t           mode_r, mode_nxt;
  logic [7:0]      sym_r, sym_nxt;
  logic            end_r, end_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            ovf_r, ovf_nxt;
  logic [CW-1:0]   top_idx;

  // Index of the top entry; only used while the stack is not empty.
  assign top_idx = cnt_r - CW'(1);

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    sym_nxt     = sym_r;
    end_nxt     = end_r;
    cnt_nxt     = cnt_r;
    ovf_nxt     = ovf_r;
    in_ready    = (state_r == ST_IDLE);
    emit        = '0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = top_idx[AW-1:0];
    mem_wr_en   = 1'b0;
    mem_wr_addr = cnt_r[AW-1:0];
    mem_wr_data = sym_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          sym_nxt = in_symbol;
          end_nxt = in_end;
          if (in_symbol == itp_pkg::CH_NUL) begin
            state_nxt = ST_ENDCHK;
          end else if (itp_pkg::is_alnum(in_symbol)) begin
            state_nxt = ST_ALNUM;
          end else if (in_symbol == itp_pkg::CH_OPEN) begin
            state_nxt = ST_PUSH;
          end else if (in_symbol == itp_pkg::CH_CLOSE) begin
            mode_nxt  = MODE_CLOSE;
            state_nxt = ST_POPRD;
          end else begin
            mode_nxt  = MODE_OP;
            state_nxt = ST_POPRD;
          end
        end
      end

      ST_ALNUM: begin
        emit.vld = 1'b1;
        emit.sym = sym_r;
        emit.ovf = ovf_r;
        if (emit_ok) begin
          state_nxt = ST_ENDCHK;
        end
      end

      // Read the top entry, or finish the pop loop on an empty stack.
      ST_POPRD: begin
        if (cnt_r == '0) begin
          case (mode_r)
            MODE_OP:    state_nxt = ST_PUSH;
            MODE_CLOSE: state_nxt = ST_ENDCHK;
            default:    state_nxt = ST_TERM;
          endcase
        end else begin
          mem_rd_en = 1'b1;
          state_nxt = ST_POPWT;
        end
      end

      // Top entry is on the RAM output: drop, stop or emit it.
      ST_POPWT: begin
        if (mode_r == MODE_CLOSE && mem_rd_data == itp_pkg::CH_OPEN) begin
          cnt_nxt   = top_idx;
          state_nxt = ST_ENDCHK;
        end else if (mode_r == MODE_OP &&
                     itp_pkg::prec_of(sym_r) > itp_pkg::prec_of(mem_rd_data)) begin
          state_nxt = ST_PUSH;
        end else begin
          emit.vld = 1'b1;
          emit.sym = mem_rd_data;
          emit.ovf = ovf_r;
          if (emit_ok) begin
            cnt_nxt   = top_idx;
            state_nxt = ST_POPRD;
          end
        end
      end

      // Push the held character; a full stack drops it and raises the flag.
      ST_PUSH: begin
        if (cnt_r >= CW'(STACK_DEPTH)) begin
          ovf_nxt = 1'b1;
        end else begin
          mem_wr_en = 1'b1;
          cnt_nxt   = cnt_r + CW'(1);
        end
        state_nxt = ST_ENDCHK;
      end

      ST_ENDCHK: begin
        if (end_r) begin
          mode_nxt  = MODE_FLUSH;
          state_nxt = ST_POPRD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      // Terminator beat; the drop flag is cleared with it.
      ST_TERM: begin
        emit.vld  = 1'b1;
        emit.sym  = itp_pkg::CH_NUL;
        emit.last = 1'b1;
        emit.ovf  = ovf_r;
        if (emit_ok) begin
          ovf_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and stack bookkeeping registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r  <= MODE_OP;
      end_r   <= 1'b0;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      end_r   <= end_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
    sym_r <= sym_nxt;
  end

endmodule

`default_nettype wire
